// ===== sv/jdc_pkg.sv =====
// Shared constants, codes and calendar helper functions for the date calculator.
package jdc_pkg;

  // Command codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SHIFT = 2'd1;
  localparam logic [1:0] OP_DIFF  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Default date
  localparam logic [3:0]  DEF_MONTH = 4'd5;
  localparam logic [4:0]  DEF_DAY   = 5'd11;
  localparam logic [13:0] DEF_YEAR  = 14'd1959;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  // Day number (from 1 Jan of year 0) of 31 Dec 9999
  localparam logic [22:0] DAY_LAST = 23'd3652424;
  // Reciprocal of 100 scaled by 2^19
  localparam logic [12:0] RECIP100 = 13'd5243;

  // Days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Gregorian leap year test
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] p;
    logic [7:0]  q;
    logic [13:0] r;
    p = 27'(y) * 27'(RECIP100);
    q = p[26:19];
    r = y - 14'(q * 8'd100);
    return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
  endfunction

  // Month length
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd2:                       n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
      default:                    n = 5'd31;
    endcase
    return n;
  endfunction

  // Days from 1 Jan of year 0 to 1 Jan of year y
  function automatic logic [22:0] days_before(input logic [13:0] y);
    logic [14:0] x;
    logic [27:0] p;
    logic [8:0]  q;
    logic [22:0] t;
    x = 15'(y) + 15'd99;
    p = 28'(x) * 28'(RECIP100);
    q = p[27:19];
    t = 23'(y) * 23'd365;
    t = t + 23'((15'(y) + 15'd3) >> 2) - 23'(q) + 23'((10'(q) + 10'd3) >> 2);
    return t;
  endfunction

  // Remainder by 7: octal digit sum, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [22:0] x);
    logic [5:0] s;
    logic [3:0] t;
    logic [3:0] u;
    s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) +
        6'(x[17:15]) + 6'(x[20:18]) + 6'(x[22:21]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    u = 4'(t[3]) + 4'(t[2:0]);
    if (u >= 4'd7) begin
      u = u - 4'd7;
    end
    return u[2:0];
  endfunction

endpackage

// ===== sv/julian_day_date_calculator.sv =====
// Date calculator top level: sequencer around one shared calendar arithmetic unit.
//
// Holds a Gregorian date (reset 11 May 1959) and takes one request at a time:
// load a date, shift it by a signed day count, or measure the absolute day
// distance to a given date. Each request yields one result with the stored
// date, its weekday (0 = Sunday), day of year, the distance and a status.
// A load or a difference, or a shift that leaves the year range, ends with
// the weekday step; an in-range shift first runs a 14-step year search
// that reuses the shared day-number unit and a 12-step month scan that
// walks the month table. The weekday is one register stage fed by a
// digit-sum remainder by 7. The input side is ready only while the sequencer
// is idle; the result register lets the next request in while a finished
// result still waits, and a further result stalls until that one is taken.
module julian_day_date_calculator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], month_in[5:2], day_in[10:6], year_in[24:11], shift_days[47:25]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // month_out[3:0], day_out[8:4], year_out[22:9], weekday[25:23],
  // day_of_year[34:26], days_between[56:35], status[58:57], zero fill above
  output logic [63:0] m_axis_tdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_YEAR  = 4'd3;
  localparam logic [3:0] S_REM   = 4'd4;
  localparam logic [3:0] S_MON   = 4'd5;
  localparam logic [3:0] S_SET   = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]         state_q;
  logic [1:0]         op_q;
  logic [3:0]         mi_q;
  logic [4:0]         di_q;
  logic [13:0]        yi_q;
  logic signed [22:0] sh_q;
  logic [3:0]         cur_m_q;
  logic [4:0]         cur_d_q;
  logic [13:0]        cur_y_q;
  logic signed [24:0] acc_q;
  logic [13:0]        ys_q;
  logic [3:0]         cnt_q;
  logic [8:0]         rem_q;
  logic               leap_q;
  logic [3:0]         nm_q;
  logic [4:0]         nd_q;
  logic [21:0]        between_q;
  logic [1:0]         status_q;
  logic [8:0]         doy_q;
  logic [2:0]         wk_q;
  logic               out_valid_q;
  logic [63:0]        out_data_q;

  // Shared unit inputs and results
  logic [13:0] cand;
  logic        in_sel;
  logic [3:0]  u_m;
  logic [4:0]  u_d;
  logic [13:0] u_y;
  logic        u_leap;
  logic [22:0] u_db;
  logic [8:0]  u_doy;
  logic [22:0] u_dn;
  logic [3:0]  mon_try;
  logic [8:0]  mon_cum;
  logic        in_ok;
  logic        s_fire;
  logic        out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign cand   = ys_q | (14'd1 << cnt_q);
  assign in_sel = (state_q == S_CALC) && (op_q != jdc_pkg::OP_SHIFT);

  // Operand select for the shared unit
  always_comb begin
    priority if (state_q == S_YEAR) begin
      u_m = cur_m_q;
      u_d = cur_d_q;
      u_y = cand;
    end else if (state_q == S_REM) begin
      u_m = cur_m_q;
      u_d = cur_d_q;
      u_y = ys_q;
    end else if (in_sel) begin
      u_m = mi_q;
      u_d = di_q;
      u_y = yi_q;
    end else begin
      u_m = cur_m_q;
      u_d = cur_d_q;
      u_y = cur_y_q;
    end
  end

  // Shared unit: leap flag, year start, day of year and day number
  assign u_leap = jdc_pkg::is_leap(u_y);
  assign u_db   = jdc_pkg::days_before(u_y);
  assign u_doy  = jdc_pkg::cum_days(u_m) + 9'((u_m > 4'd2) && u_leap) + 9'(u_d);
  assign u_dn   = u_db + 23'(u_doy) - 23'd1;
  assign in_ok  = (mi_q >= 4'd1) && (mi_q <= 4'd12) && (yi_q <= jdc_pkg::YEAR_MAX) &&
                  (di_q >= 5'd1) && (di_q <= jdc_pkg::month_len(mi_q, u_leap));

  assign mon_try = cnt_q + 4'd1;
  assign mon_cum = jdc_pkg::cum_days(mon_try) + 9'((mon_try > 4'd2) && leap_q);

  // Sequencer and stored date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_m_q     <= jdc_pkg::DEF_MONTH;
      cur_d_q     <= jdc_pkg::DEF_DAY;
      cur_y_q     <= jdc_pkg::DEF_YEAR;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            op_q      <= s_axis_tdata[1:0];
            mi_q      <= s_axis_tdata[5:2];
            di_q      <= s_axis_tdata[10:6];
            yi_q      <= s_axis_tdata[24:11];
            sh_q      <= s_axis_tdata[47:25];
            status_q  <= jdc_pkg::ST_OK;
            between_q <= '0;
            state_q   <= S_CALC;
          end
        end
        S_CALC: begin
          unique case (op_q)
            jdc_pkg::OP_LOAD: begin
              if (in_ok) begin
                cur_m_q <= mi_q;
                cur_d_q <= di_q;
                cur_y_q <= yi_q;
              end else begin
                cur_m_q  <= jdc_pkg::DEF_MONTH;
                cur_d_q  <= jdc_pkg::DEF_DAY;
                cur_y_q  <= jdc_pkg::DEF_YEAR;
                status_q <= jdc_pkg::ST_INVALID;
              end
              state_q <= S_FIN;
            end
            jdc_pkg::OP_SHIFT: begin
              acc_q   <= $signed({2'b00, u_dn}) + $signed({{2{sh_q[22]}}, sh_q});
              state_q <= S_RANGE;
            end
            jdc_pkg::OP_DIFF: begin
              if (in_ok) begin
                acc_q   <= $signed({2'b00, u_dn});
                state_q <= S_DIFF;
              end else begin
                status_q <= jdc_pkg::ST_INVALID;
                state_q  <= S_FIN;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_RANGE: begin
          if (acc_q[24] || (acc_q[23:0] > 24'(jdc_pkg::DAY_LAST))) begin
            status_q <= jdc_pkg::ST_RANGE;
            state_q  <= S_FIN;
          end else begin
            ys_q    <= '0;
            cnt_q   <= 4'd13;
            state_q <= S_YEAR;
          end
        end
        // Binary search for the largest year starting at or before the day
        S_YEAR: begin
          if ((cand <= jdc_pkg::YEAR_MAX) && (u_db <= acc_q[22:0])) begin
            ys_q <= cand;
          end
          if (cnt_q == 4'd0) begin
            state_q <= S_REM;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_REM: begin
          rem_q   <= 9'(acc_q[22:0] - u_db);
          leap_q  <= u_leap;
          cnt_q   <= '0;
          state_q <= S_MON;
        end
        // Linear month scan over the cumulative table
        S_MON: begin
          if (rem_q >= mon_cum) begin
            nm_q <= mon_try;
            nd_q <= 5'(rem_q - mon_cum + 9'd1);
          end
          if (cnt_q == 4'd11) begin
            state_q <= S_SET;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_SET: begin
          cur_m_q <= nm_q;
          cur_d_q <= nd_q;
          cur_y_q <= ys_q;
          state_q <= S_FIN;
        end
        S_DIFF: begin
          if ($signed({2'b00, u_dn}) >= acc_q) begin
            between_q <= 22'(u_dn - acc_q[22:0]);
          end else begin
            between_q <= 22'(acc_q[22:0] - u_dn);
          end
          state_q <= S_FIN;
        end
        // Day number offset for the weekday, and day of year
        S_FIN: begin
          acc_q   <= $signed({2'b00, u_dn + 23'd6});
          doy_q   <= u_doy;
          state_q <= S_MOD;
        end
        // Weekday: (day number + 6) mod 7
        S_MOD: begin
          wk_q    <= jdc_pkg::mod7(acc_q[22:0]);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {5'd0, status_q, between_q, doy_q, wk_q, cur_y_q, cur_d_q, cur_m_q};
    end
  end

endmodule
